FILE: rtl/bb_pkg.sv
// Package: shared constants and types for the box blur core.
package bb_pkg;
   localparam int IMAGE_SIZE_DEF = 256;
   localparam int WINDOW_DEF = 10;
   localparam int NUM_LANES = 3;
   localparam int PIX_W = 8;

   typedef logic [PIX_W-1:0] pix_type;

   // Request sequencing: read RAMs, update sums, divide, hold the response.
   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CALC, ST_DIV, ST_OUT
   } bb_fsm_type;

   // Control that travels down the pipeline beside the lane data.
   typedef struct packed {
      logic        first_row;   // r == 0
      logic        drop_line;   // r >= WINDOW
      logic        first_col;   // c == 0
      logic        drop_col;    // c >= WINDOW
      logic        last_pix;    // top-left pixel
   } lane_ctl_type;
endpackage

FILE: rtl/box_blur_10x10_rgb_core.sv
// Top level: streaming RGB box blur with reverse raster input order.
// Per request: RAM read, sum update, SUM_W (15) divide steps, result register.
// Requests are taken one at a time: req_stall holds while the bit-serial divider in
// the merge stage works and until the response is taken.
// Reset: synchronous, active high; clears counters, window sums and control.
// Line store and column sums need no clearing; each frame writes before reads.
module box_blur_10x10_rgb_core #(
   parameter int IMAGE_SIZE = bb_pkg::IMAGE_SIZE_DEF,
   parameter int WINDOW = bb_pkg::WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bb_pkg::pix_type   req_pixel_red,
   input  bb_pkg::pix_type   req_pixel_green,
   input  bb_pkg::pix_type   req_pixel_blue,
   input  logic              req_start_of_frame,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bb_pkg::pix_type   rsp_mean_red,
   output bb_pkg::pix_type   rsp_mean_green,
   output bb_pkg::pix_type   rsp_mean_blue,
   output logic              rsp_end_of_frame
);
   import bb_pkg::*;

   localparam int POS_W = $clog2(IMAGE_SIZE);
   localparam int WIN_W = $clog2(WINDOW);
   localparam int LINE_D = WINDOW * IMAGE_SIZE;
   localparam int LINE_A = $clog2(LINE_D);
   localparam int COL_W = $clog2(WINDOW * 255 + 1);
   localparam int SUM_W = $clog2(WINDOW * WINDOW * 255 + 1);
   localparam int CNT_W = $clog2(WINDOW * WINDOW + 1);
   localparam int WIN1_W = $clog2(WINDOW + 1);

   bb_fsm_type state_ff, state_in;

   // Position and running state.
   logic [POS_W-1:0] row_ff, col_ff, c_ff;
   logic [WIN_W-1:0] rmod_ff;      // row index modulo WINDOW
   logic [WIN_W-1:0] rmod_cur_ff;
   logic [SUM_W-1:0] win_ff [NUM_LANES];
   pix_type          pix_ff [NUM_LANES];
   lane_ctl_type     ctl_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [LINE_A-1:0] line_addr;
   logic [3*PIX_W-1:0] line_rd;
   logic [3*COL_W-1:0] col_rd, col_far_rd;
   logic [3*COL_W-1:0] col_wr;
   logic [NUM_LANES*SUM_W-1:0] div_in;
   logic [NUM_LANES*PIX_W-1:0] div_q;
   logic div_busy, div_done;
   logic [COL_W-1:0] cs_new [NUM_LANES];
   logic [SUM_W-1:0] ws_new [NUM_LANES];
   logic [NUM_LANES*PIX_W-1:0] out_ff;
   logic out_valid_ff, out_eof_ff;

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_CALC;
         ST_CALC: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  if (!out_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Latch the request and its position; advance counters.
   logic [POS_W-1:0] r_cur, c_cur;
   logic [WIN_W-1:0] rm_cur;
   always_comb begin
      r_cur = req_start_of_frame ? '0 : row_ff;
      c_cur = req_start_of_frame ? '0 : col_ff;
      rm_cur = req_start_of_frame ? '0 : rmod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         rmod_ff <= '0;
      end else if (accept) begin
         if (c_cur == POS_W'(IMAGE_SIZE - 1)) begin
            col_ff <= '0;
            row_ff <= (r_cur == POS_W'(IMAGE_SIZE - 1)) ? '0 : r_cur + 1'b1;
            if (r_cur == POS_W'(IMAGE_SIZE - 1) || rm_cur == WIN_W'(WINDOW - 1))
               rmod_ff <= '0;
            else
               rmod_ff <= rm_cur + 1'b1;
         end else begin
            col_ff <= c_cur + 1'b1;
            row_ff <= r_cur;
            rmod_ff <= rm_cur;
         end
      end
   end

   logic [WIN1_W-1:0] rows_in, cols_in;
   always_comb begin
      rows_in = (32'(r_cur) + 1 < WINDOW) ? WIN1_W'(r_cur + 1'b1) : WIN1_W'(WINDOW);
      cols_in = (32'(c_cur) + 1 < WINDOW) ? WIN1_W'(c_cur + 1'b1) : WIN1_W'(WINDOW);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff <= c_cur;
         rmod_cur_ff <= rm_cur;
         pix_ff[0] <= req_pixel_red;
         pix_ff[1] <= req_pixel_green;
         pix_ff[2] <= req_pixel_blue;
         ctl_ff.first_row <= (r_cur == '0);
         ctl_ff.drop_line <= (32'(r_cur) >= WINDOW);
         ctl_ff.first_col <= (c_cur == '0);
         ctl_ff.drop_col <= (32'(c_cur) >= WINDOW);
         ctl_ff.last_pix <= (r_cur == POS_W'(IMAGE_SIZE - 1)) &&
                            (c_cur == POS_W'(IMAGE_SIZE - 1));
         cnt_ff <= CNT_W'(rows_in) * CNT_W'(cols_in);
      end
   end

   assign line_addr = LINE_A'(32'(rmod_cur_ff) * IMAGE_SIZE + 32'(c_ff));
   logic calc;
   assign calc = (state_ff == ST_CALC);

   bb_ram #(.WIDTH(3*PIX_W), .DEPTH(LINE_D)) u_line (
      .clock(clock), .wr_en(calc), .wr_addr(line_addr),
      .wr_data({pix_ff[2], pix_ff[1], pix_ff[0]}),
      .rd_en(state_ff == ST_READ), .rd_addr(line_addr), .rd_data(line_rd));

   bb_ram #(.WIDTH(3*COL_W), .DEPTH(IMAGE_SIZE)) u_col (
      .clock(clock), .wr_en(calc), .wr_addr(c_ff), .wr_data(col_wr),
      .rd_en(state_ff == ST_READ), .rd_addr(c_ff), .rd_data(col_rd));

   // Second copy of column sums for the column leaving the window.
   bb_ram #(.WIDTH(3*COL_W), .DEPTH(IMAGE_SIZE)) u_col_far (
      .clock(clock), .wr_en(calc), .wr_addr(c_ff), .wr_data(col_wr),
      .rd_en(state_ff == ST_READ), .rd_addr(c_ff - POS_W'(WINDOW)),
      .rd_data(col_far_rd));

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      logic [SUM_W-1:0] cs_w;
      bb_lane #(.SUM_W(SUM_W)) u_lane (
         .pix(pix_ff[k]), .old_pix(line_rd[k*PIX_W +: PIX_W]),
         .col_sum_old(SUM_W'(col_rd[k*COL_W +: COL_W])),
         .col_sum_far(SUM_W'(col_far_rd[k*COL_W +: COL_W])),
         .win_sum_old(win_ff[k]), .ctl(ctl_ff),
         .col_sum_new(cs_w), .win_sum_new(ws_new[k]));
      assign cs_new[k] = cs_w[COL_W-1:0];
      assign col_wr[k*COL_W +: COL_W] = cs_new[k];
      assign div_in[k*SUM_W +: SUM_W] = ws_new[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LANES; k++) win_ff[k] <= '0;
      end else if (calc) begin
         for (int k = 0; k < NUM_LANES; k++) win_ff[k] <= ws_new[k];
      end
   end

   bb_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
      .clock(clock), .reset(reset), .start(calc), .dividend(div_in),
      .divisor(cnt_ff), .busy(div_busy), .done(div_done), .quotient(div_q));

   // Output register: hold until the response is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (div_done && !div_busy) out_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         out_ff <= div_q;
         out_eof_ff <= ctl_ff.last_pix;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_mean_red = out_ff[0 +: PIX_W];
   assign rsp_mean_green = out_ff[PIX_W +: PIX_W];
   assign rsp_mean_blue = out_ff[2*PIX_W +: PIX_W];
   assign rsp_end_of_frame = out_eof_ff;
endmodule

FILE: rtl/bb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/bb_lane.sv
// One color lane: column sum update and running window sum.
module bb_lane #(
   parameter int SUM_W = 16
) (
   input  bb_pkg::pix_type      pix,
   input  bb_pkg::pix_type      old_pix,
   input  logic [SUM_W-1:0]     col_sum_old,
   input  logic [SUM_W-1:0]     col_sum_far,
   input  logic [SUM_W-1:0]     win_sum_old,
   input  bb_pkg::lane_ctl_type ctl,
   output logic [SUM_W-1:0]     col_sum_new,
   output logic [SUM_W-1:0]     win_sum_new
);
   import bb_pkg::*;
   logic [SUM_W-1:0] cs;
   logic [SUM_W-1:0] ws;

   always_comb begin
      cs = ctl.first_row ? '0 : col_sum_old;
      if (ctl.drop_line) begin
         cs = cs - SUM_W'(old_pix);
      end
      cs = cs + SUM_W'(pix);
      ws = ctl.first_col ? '0 : win_sum_old;
      ws = ws + cs;
      if (ctl.drop_col) begin
         ws = ws - col_sum_far;
      end
   end

   assign col_sum_new = cs;
   assign win_sum_new = ws;
endmodule

FILE: rtl/bb_div.sv
// Merge stage: restoring divider sharing one count across all lanes.
module bb_div #(
   parameter int SUM_W = 16,
   parameter int CNT_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bb_pkg::NUM_LANES*SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]                divisor,
   output logic                            busy,
   output logic                            done,
   output logic [bb_pkg::NUM_LANES*bb_pkg::PIX_W-1:0] quotient
);
   import bb_pkg::*;
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff [NUM_LANES];
   logic [SUM_W-1:0] quo_in [NUM_LANES];
   logic [CNT_W:0]   rem_ff [NUM_LANES];
   logic [CNT_W:0]   rem_in [NUM_LANES];
   logic [CNT_W-1:0] den_ff;
   logic [STEP_W-1:0] step_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W:0]   trial [NUM_LANES];

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         trial[k] = {rem_ff[k][CNT_W-1:0], quo_ff[k][SUM_W-1]};
         quo_in[k] = {quo_ff[k][SUM_W-2:0], 1'b0};
         rem_in[k] = trial[k];
         if (trial[k] >= {1'b0, den_ff}) begin
            rem_in[k] = trial[k] - {1'b0, den_ff};
            quo_in[k][0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor;
         for (int k = 0; k < NUM_LANES; k++) begin
            quo_ff[k] <= dividend[k*SUM_W +: SUM_W];
            rem_ff[k] <= '0;
         end
      end else if (busy_ff) begin
         for (int k = 0; k < NUM_LANES; k++) begin
            quo_ff[k] <= quo_in[k];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         quotient[k*PIX_W +: PIX_W] = quo_ff[k][PIX_W-1:0];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
endmodule
